// File: sv/sacl_pkg.sv
// Shared types, constants and geometry for the set-associative LRU cache counter.
package sacl_pkg;

    // Geometry.
    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int STAMP_WIDTH  = 32;

    localparam int SETS    = 1 << MAX_SET_BITS;
    localparam int SET_W   = MAX_SET_BITS;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NODES   = 1 << WAY_W;
    localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
    localparam int SETB_W  = $clog2(MAX_SET_BITS + 1);

    // Field widths.
    localparam int ADDR_W     = 64;
    localparam int OP_W       = 2;
    localparam int TOTAL_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int SBITS_W    = 3;
    localparam int BOFF_W     = 6;
    localparam int WAYS_W     = 4;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] address;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         hits_now;
        logic               missed;
        logic               evicted;
        logic [TOTAL_W-1:0] total_hits;
        logic [TOTAL_W-1:0] total_misses;
        logic [TOTAL_W-1:0] total_evictions;
    } t_out_word;

    // Effective (clamped) geometry handed to the datapath.
    typedef struct packed {
        logic [SETB_W-1:0] sbits;
        logic [BOFF_W-1:0] boff;
        logic [WCNT_W-1:0] ways;
    } t_geom;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic read_row;
        logic eval;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

// File: sv/sacl_ctrl.sv
// Sequencer for one cache access: take word, read set, compare ways, write back.
module sacl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  sacl_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output sacl_pkg::t_dp_cmd o_cmd
);
    import sacl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.read_row = 1'b1;
                n_state        = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.eval = 1'b1;
                n_state    = ST_WRITE;
            end
            ST_WRITE: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/sacl_dp.sv
// Datapath: set store, way compare, LRU victim tree, stamp and totals, output register.
module sacl_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sacl_pkg::t_dp_cmd   i_cmd,
    input  sacl_pkg::t_geom     i_geom,
    input  sacl_pkg::t_in_word  i_in_word,
    input  logic                i_out_ready,
    output sacl_pkg::t_dp_stat  o_stat,
    output logic                o_out_valid,
    output sacl_pkg::t_out_word o_out_word
);
    import sacl_pkg::*;

    // Set store: one row per set, all ways side by side.
    logic [MAX_WAYS-1:0][ADDR_W-1:0]      mem_tag   [SETS];
    logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] mem_stamp [SETS];
    logic [MAX_WAYS-1:0]                  mem_valid [SETS];
    logic [SETS-1:0]                      r_row_init;

    logic [OP_W-1:0]   r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_tag;
    logic [SET_W-1:0]  r_set;

    logic [MAX_WAYS-1:0][ADDR_W-1:0]      r_rd_tag;
    logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] r_rd_stamp;
    logic [MAX_WAYS-1:0]                  r_rd_valid;
    logic                                 r_rd_init;
    logic [MAX_WAYS-1:0]                  rd_valid;

    logic [WAY_W-1:0]  r_way;
    logic              r_hit;
    logic              r_miss;
    logic              r_evict;
    logic [WCNT_W-1:0] r_adv;

    logic [STAMP_WIDTH-1:0] r_stamp_ctr;
    logic [TOTAL_W-1:0]     r_tot_hits;
    logic [TOTAL_W-1:0]     r_tot_misses;
    logic [TOTAL_W-1:0]     r_tot_evicts;

    logic      r_out_valid;
    t_out_word r_out_word;

    // Address split.
    logic [ADDR_W-1:0] shifted;
    logic [ADDR_W-1:0] n_tag;
    logic [SET_W-1:0]  n_set;

    assign shifted = r_addr >> i_geom.boff;
    assign n_tag   = shifted >> i_geom.sbits;
    assign n_set   = shifted[SET_W-1:0] & ~({SET_W{1'b1}} << i_geom.sbits);

    // Mask valid bits of rows never written since reset.
    assign rd_valid = {MAX_WAYS{r_rd_init}} & r_rd_valid;

    // Way probe and victim search.
    logic [MAX_WAYS-1:0] in_use;
    logic [MAX_WAYS-1:0] stop;
    logic                found;
    logic [WAY_W-1:0]    found_idx;
    logic [STAMP_WIDTH-1:0] lv_stamp [WAY_W+1][NODES];
    logic [WAY_W-1:0]       lv_idx   [WAY_W+1][NODES];
    logic                   lv_ok    [WAY_W+1][NODES];
    logic                   take_left;

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            in_use[w] = (WCNT_W'(w) < i_geom.ways);
            stop[w]   = in_use[w] & (~rd_valid[w] | (r_rd_tag[w] == r_tag));
        end
        // first way that stops the probe
        found     = 1'b0;
        found_idx = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (stop[w]) begin
                found     = 1'b1;
                found_idx = WAY_W'(w);
            end
        end
        // least stamp over the ways in use, lower way wins a tie
        take_left = 1'b0;
        for (int l = 0; l <= WAY_W; l++) begin
            for (int i = 0; i < NODES; i++) begin
                lv_stamp[l][i] = '0;
                lv_idx[l][i]   = '0;
                lv_ok[l][i]    = 1'b0;
            end
        end
        for (int i = 0; i < NODES; i++) begin
            if (i < MAX_WAYS) begin
                lv_stamp[0][i] = r_rd_stamp[i];
                lv_ok[0][i]    = in_use[i];
            end
            lv_idx[0][i] = WAY_W'(i);
        end
        for (int l = 0; l < WAY_W; l++) begin
            for (int i = 0; i < (NODES >> (l + 1)); i++) begin
                take_left = lv_ok[l][2*i] &
                            (~lv_ok[l][2*i+1] | (lv_stamp[l][2*i] <= lv_stamp[l][2*i+1]));
                lv_stamp[l+1][i] = take_left ? lv_stamp[l][2*i] : lv_stamp[l][2*i+1];
                lv_idx[l+1][i]   = take_left ? lv_idx[l][2*i]   : lv_idx[l][2*i+1];
                lv_ok[l+1][i]    = lv_ok[l][2*i] | lv_ok[l][2*i+1];
            end
        end
    end

    // Commit values.
    logic [STAMP_WIDTH-1:0]               new_stamp;
    logic [1:0]                           hits_now;
    logic [TOTAL_W:0]                     sum_hits;
    logic [TOTAL_W:0]                     sum_misses;
    logic [TOTAL_W:0]                     sum_evicts;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]      wr_tag;
    logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] wr_stamp;
    logic [MAX_WAYS-1:0]                  wr_valid;

    always_comb begin
        new_stamp  = r_stamp_ctr + STAMP_WIDTH'(r_adv);
        hits_now   = {1'b0, r_hit} + {1'b0, (r_op == OP_MODIFY)};
        sum_hits   = {1'b0, r_tot_hits}   + (TOTAL_W+1)'(hits_now);
        sum_misses = {1'b0, r_tot_misses} + (TOTAL_W+1)'(r_miss);
        sum_evicts = {1'b0, r_tot_evicts} + (TOTAL_W+1)'(r_evict);
        wr_tag          = r_rd_tag;
        wr_stamp        = r_rd_stamp;
        wr_valid        = rd_valid;
        wr_tag[r_way]   = r_tag;
        wr_stamp[r_way] = new_stamp;
        wr_valid[r_way] = 1'b1;
    end

    // Memory: read on read_row, write on commit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.read_row) begin
            r_rd_tag   <= mem_tag[n_set];
            r_rd_stamp <= mem_stamp[n_set];
            r_rd_valid <= mem_valid[n_set];
        end
        if (i_cmd.commit) begin
            mem_tag[r_set]   <= wr_tag;
            mem_stamp[r_set] <= wr_stamp;
            mem_valid[r_set] <= wr_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= i_in_word.op;
            r_addr <= i_in_word.address;
        end
        if (i_cmd.read_row) begin
            r_tag <= n_tag;
            r_set <= n_set;
        end
        if (i_cmd.eval) begin
            r_way   <= found ? found_idx : lv_idx[WAY_W][0];
            r_hit   <= found & rd_valid[found_idx];
            r_miss  <= ~(found & rd_valid[found_idx]);
            r_evict <= ~found;
            r_adv   <= found ? WCNT_W'(found_idx) + WCNT_W'(1) : i_geom.ways;
        end
        if (i_cmd.commit) begin
            r_out_word.hits_now        <= hits_now;
            r_out_word.missed          <= r_miss;
            r_out_word.evicted         <= r_evict;
            r_out_word.total_hits      <= sum_hits[TOTAL_W]   ? '1 : sum_hits[TOTAL_W-1:0];
            r_out_word.total_misses    <= sum_misses[TOTAL_W] ? '1 : sum_misses[TOTAL_W-1:0];
            r_out_word.total_evictions <= sum_evicts[TOTAL_W] ? '1 : sum_evicts[TOTAL_W-1:0];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_init   <= '0;
            r_stamp_ctr  <= '0;
            r_tot_hits   <= '0;
            r_tot_misses <= '0;
            r_tot_evicts <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_row_init[r_set] <= 1'b1;
                r_stamp_ctr       <= new_stamp;
                r_tot_hits   <= sum_hits[TOTAL_W]   ? '1 : sum_hits[TOTAL_W-1:0];
                r_tot_misses <= sum_misses[TOTAL_W] ? '1 : sum_misses[TOTAL_W-1:0];
                r_tot_evicts <= sum_evicts[TOTAL_W] ? '1 : sum_evicts[TOTAL_W-1:0];
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Row-initialized flag read alongside the set; gates stale valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_init <= 1'b0;
        end else if (i_cmd.read_row) begin
            r_rd_init <= r_row_init[n_set];
        end
    end

    assign o_stat.out_free = ~r_out_valid | i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_word      = r_out_word;

endmodule

// File: sv/set_assoc_cache_lru_counter.sv
// Top level of the set-associative LRU cache hit/miss/eviction counter.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_word) takes one access word:
//   op (load, store, modify) and a 64-bit byte address. Output channel
//   (o_out_valid / i_out_ready / o_out_word) returns one result word per
//   access: hits of this access, miss and eviction flags, and the three
//   saturating running totals.
//   Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index /
//   i_cfg_data) writes set bits (0), block offset bits (1) and ways (2);
//   it is always ready. Write it only while no access is in flight.
// Timing:
//   An access runs through four controller steps: take word, read the set
//   row from the set store, compare ways and search the LRU victim, write
//   the row back. The result is registered at write-back, and the next word
//   is taken only after the previous one is written back (the four steps
//   run one after another; write-back waits while the output is still full).
// Reset: clears all lines to invalid (per-row flags, no sweep), the stamp
//   counter and the totals; geometry returns to 4 set bits, 4 offset bits,
//   1 way. A stalled receiver holds the result; the input side may still
//   take one more word and park it at write-back until the output frees.
module set_assoc_cache_lru_counter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  sacl_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output sacl_pkg::t_out_word                 o_out_word,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import sacl_pkg::*;

    logic [SBITS_W-1:0] r_set_bits;
    logic [BOFF_W-1:0]  r_offset_bits;
    logic [WAYS_W-1:0]  r_ways;

    t_geom    geom;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Configuration registers; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits    <= SBITS_W'(4);
            r_offset_bits <= BOFF_W'(4);
            r_ways        <= WAYS_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SET_BITS:    r_set_bits    <= i_cfg_data[SBITS_W-1:0];
                CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data[BOFF_W-1:0];
                CFG_WAYS:        r_ways        <= i_cfg_data[WAYS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Clamp geometry: set bits to the store size, ways to 1..MAX_WAYS.
    always_comb begin
        geom.boff  = r_offset_bits;
        geom.sbits = (int'(r_set_bits) > MAX_SET_BITS) ? SETB_W'(MAX_SET_BITS)
                                                       : SETB_W'(r_set_bits);
        if (r_ways == '0) begin
            geom.ways = WCNT_W'(1);
        end else if (int'(r_ways) > MAX_WAYS) begin
            geom.ways = WCNT_W'(MAX_WAYS);
        end else begin
            geom.ways = WCNT_W'(r_ways);
        end
    end

    sacl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    sacl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_geom      (geom),
        .i_in_word   (i_in_word),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

// File: tb/sv/set_assoc_cache_lru_counter_tb.sv
// Self-checking testbench for the set-associative LRU cache hit/miss/eviction counter.

class lru_tally_board;
    localparam int LINES = sacl_pkg::SETS * sacl_pkg::MAX_WAYS;

    bit [2:0]  set_bits_reg;
    bit [5:0]  offset_bits_reg;
    bit [3:0]  ways_reg;
    bit        line_live [LINES];
    bit [63:0] line_tag  [LINES];
    bit [31:0] line_age  [LINES];
    bit [31:0] age_clock;
    bit [31:0] hit_sum;
    bit [31:0] miss_sum;
    bit [31:0] evict_sum;
    sacl_pkg::t_out_word pending_tallies[$];
    int        errors;

    function new();
        set_bits_reg    = 4;
        offset_bits_reg = 4;
        ways_reg        = 1;
        foreach (line_live[k]) line_live[k] = 1'b0;
        age_clock = 0;
        hit_sum   = 0;
        miss_sum  = 0;
        evict_sum = 0;
        errors    = 0;
    endfunction

    function void write_reg(logic [sacl_pkg::CFG_IDX_W-1:0] index,
                            logic [sacl_pkg::CFG_DATA_W-1:0] data);
        case (index)
            sacl_pkg::CFG_SET_BITS:    set_bits_reg    = data[2:0];
            sacl_pkg::CFG_OFFSET_BITS: offset_bits_reg = data;
            sacl_pkg::CFG_WAYS:        ways_reg        = data[3:0];
            default: ;
        endcase
    endfunction

    function bit [31:0] sat_inc(bit [31:0] acc, bit [1:0] inc);
        bit [32:0] sum;
        sum = {1'b0, acc} + inc;
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // Probe the set for one access word and queue the tally it must produce.
    function void note_access(sacl_pkg::t_in_word acc_word);
        int unsigned         sbits, nways, base, victim, k;
        bit [63:0]           shifted, tag, set_mask;
        bit [1:0]            hits;
        bit                  miss, evict, done;
        sacl_pkg::t_out_word t;
        sbits = (set_bits_reg > sacl_pkg::MAX_SET_BITS) ? sacl_pkg::MAX_SET_BITS : set_bits_reg;
        nways = (ways_reg == 0) ? 1 :
                (ways_reg > sacl_pkg::MAX_WAYS) ? sacl_pkg::MAX_WAYS : ways_reg;
        shifted  = acc_word.address >> offset_bits_reg;
        tag      = shifted >> sbits;
        set_mask = (64'd1 << sbits) - 64'd1;
        base     = int'(shifted & set_mask) * sacl_pkg::MAX_WAYS;
        hits  = 0;
        miss  = 0;
        evict = 0;
        done  = 0;
        for (int w = 0; w < nways && !done; w++) begin
            k = base + w;
            age_clock++;
            if (!line_live[k]) begin
                miss         = 1;
                line_live[k] = 1;
                line_tag[k]  = tag;
                line_age[k]  = age_clock;
                done         = 1;
            end else if (line_tag[k] == tag) begin
                hits        = 1;
                line_age[k] = age_clock;
                done        = 1;
            end
        end
        if (!done) begin
            // oldest stamp goes, strict compare keeps the lowest way on a tie
            victim = 0;
            for (int w = 1; w < nways; w++) begin
                if (line_age[base + w] < line_age[base + victim]) victim = w;
            end
            miss  = 1;
            evict = 1;
            line_tag[base + victim] = tag;
            line_age[base + victim] = age_clock;
        end
        if (acc_word.op == sacl_pkg::OP_MODIFY) hits++;
        hit_sum   = sat_inc(hit_sum, hits);
        miss_sum  = sat_inc(miss_sum, {1'b0, miss});
        evict_sum = sat_inc(evict_sum, {1'b0, evict});
        t.hits_now        = hits;
        t.missed          = miss;
        t.evicted         = evict;
        t.total_hits      = hit_sum;
        t.total_misses    = miss_sum;
        t.total_evictions = evict_sum;
        pending_tallies.push_back(t);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        if (errors < 40) $display("[%0t] mismatch %s: got %0h want %0h", $time, what, got, want);
        errors++;
    endtask

    task check_result(sacl_pkg::t_out_word got);
        sacl_pkg::t_out_word want;
        if (pending_tallies.size() == 0) begin
            report("result with no access pending", got.total_hits, 0);
            return;
        end
        want = pending_tallies.pop_front();
        if (got.hits_now !== want.hits_now)   report("hits_now", got.hits_now, want.hits_now);
        if (got.missed !== want.missed)       report("missed", got.missed, want.missed);
        if (got.evicted !== want.evicted)     report("evicted", got.evicted, want.evicted);
        if (got.total_hits !== want.total_hits)
            report("total_hits", got.total_hits, want.total_hits);
        if (got.total_misses !== want.total_misses)
            report("total_misses", got.total_misses, want.total_misses);
        if (got.total_evictions !== want.total_evictions)
            report("total_evictions", got.total_evictions, want.total_evictions);
    endtask
endclass

module set_assoc_cache_lru_counter_tb;
    import sacl_pkg::*;

    // Op codes the package leaves unnamed; the spare one must act as a load.
    localparam logic [OP_W-1:0]      OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0]      OP_STORE  = 2'd1;
    localparam logic [OP_W-1:0]      OP_SPARE  = 2'd3;
    // Unused register slot: writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int IDLE_LIMIT    = 400;  // cycles without any handshake
    localparam int SETTLE_CYCLES = 6;    // extra wait; write-back lands with the result word
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 62;
    localparam int BURST_ITEMS   = 15;   // words sent back to back at phase start

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_word              in_word;
    logic                  out_valid;
    logic                  rx_ready;
    t_out_word             out_word;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    idle_cycles = 0;
    lru_tally_board        tally;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    set_assoc_cache_lru_counter uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (rx_ready),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Sample every handshake at the edge: predict on an accepted access word,
    // track register writes, compare each accepted result word.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) tally.note_access(in_word);
            if (cfg_valid && cfg_ready) tally.write_reg(cfg_index, cfg_data);
            if (out_valid && rx_ready) tally.check_result(out_word);
        end
    end

    // Watchdog: count cycles in which no channel moves a word.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && rx_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: stall at random before each word, with
    // stretches of full-rate draining in between.
    initial begin : result_sink
        int stall;
        int taken;
        taken = 0;
        rx_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = (taken % 90 < 25) ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
                rx_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rx_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && rx_ready)) @(posedge clk);
            taken++;
        end
    end

    // Send one access word; hold valid and payload until the block takes it.
    task automatic send_access(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                               input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_word  <= {op, addr};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!(in_valid && in_ready)) @(posedge clk);
    endtask

    // Drop valid and hold until every result is back and write-back is done.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tally.pending_tallies.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all registers, the spare slot last, keeping valid high between them.
    task automatic set_geometry(input logic [CFG_DATA_W-1:0] sbits, boff, ways);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        idx[0] = CFG_SET_BITS;    val[0] = sbits;
        idx[1] = CFG_OFFSET_BITS; val[1] = boff;
        idx[2] = CFG_WAYS;        val[2] = ways;
        idx[3] = CFG_SPARE;       val[3] = CFG_DATA_W'($urandom_range(0, 63));
        for (int i = 0; i < 4; i++) begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!(cfg_valid && cfg_ready)) @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed addresses: a few sets, a tag pool just larger than
    // the ways so that hits and evictions both happen; the rest is noise.
    function automatic logic [63:0] pick_address(int sbits, int boff, int nways,
                                                 logic [63:0] tag_base);
        logic [63:0] tag, set_no, offs;
        if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
        tag    = tag_base + 64'($urandom_range(0, nways + 1));
        set_no = 64'($urandom_range(0, 2)) & ((64'd1 << sbits) - 64'd1);
        offs   = {$urandom, $urandom} & ((64'd1 << boff) - 64'd1);
        return (tag << (boff + sbits)) | (set_no << boff) | offs;
    endfunction

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] s_raw, o_raw, w_raw;
        int                    s_eff, w_eff;
        logic [63:0]           tag_base;
        tally = new();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_word   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SET_BITS;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words under reset geometry: 16 sets, 16-byte blocks, one way.
        send_access(OP_LOAD,   64'h0, 1'b0);                  // cold miss
        send_access(OP_STORE,  64'h8, 1'b0);                  // same block hits
        send_access(OP_MODIFY, 64'h0, 1'b0);                  // hit plus modify hit
        send_access(OP_LOAD,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1); // top set, top tag
        send_access(OP_SPARE,  64'hFFFF_FFFF_FFFF_FFF0, 1'b1); // spare op acts as load
        send_access(OP_LOAD,   64'h100, 1'b0);                // evict in set 0
        send_access(OP_MODIFY, 64'h200, 1'b1);                // miss, evict, one hit
        send_access(OP_STORE,  64'h100, 1'b0);
        send_access(OP_LOAD,   64'h8000_0000_0000_0000, 1'b0);
        send_access(OP_MODIFY, 64'h8000_0000_0000_000F, 1'b1);
        send_access(OP_SPARE,  64'h5555_5555_5555_5555, 1'b0);
        send_access(OP_STORE,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin s_raw = 6'd6;  o_raw = 6'd32; w_raw = 6'd8;  end // widest legal
                1: begin s_raw = 6'd1;  o_raw = 6'd1;  w_raw = 6'd2;  end // narrowest legal
                2: begin s_raw = 6'h38; o_raw = 6'd0;  w_raw = 6'd0;  end // one set, one way
                3: begin s_raw = 6'd7;  o_raw = 6'd63; w_raw = 6'hF; end // clamp set bits and ways
                4: begin s_raw = 6'd3;  o_raw = 6'd5;  w_raw = 6'd4;  end
                5: begin s_raw = 6'h3A; o_raw = 6'd12; w_raw = 6'h39; end // upper data bits
                default: begin s_raw = 6'd5; o_raw = 6'd20; w_raw = 6'd3; end
            endcase
            wait_idle();
            set_geometry(s_raw, o_raw, w_raw);
            s_eff    = (s_raw[2:0] > MAX_SET_BITS) ? MAX_SET_BITS : s_raw[2:0];
            w_eff    = (w_raw[3:0] == 0) ? 1 : (w_raw[3:0] > MAX_WAYS) ? MAX_WAYS : w_raw[3:0];
            tag_base = {$urandom, $urandom};
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_access(OP_W'($urandom_range(0, 3)),
                            pick_address(s_eff, int'(o_raw), w_eff, tag_base),
                            n < BURST_ITEMS);
            end
        end

        wait_idle();
        if (tally.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// File: filelist.f
sv/sacl_pkg.sv
sv/sacl_ctrl.sv
sv/sacl_dp.sv
sv/set_assoc_cache_lru_counter.sv
tb/sv/set_assoc_cache_lru_counter_tb.sv
